FILE: rtl/mrt_pkg.sv
// Shared types, constants and helpers of the midpoint ray triangulation block.
// Depends on nothing; mrt_ray, mrt_solve and the top level take names from here.
`timescale 1ns / 1ps
package mrt_pkg;
  localparam int RAY_W = 20;
  localparam int F2_W = 22;
  localparam int IDX_W = 3;
  localparam int CFG_W = 64;
  localparam int PX_W = 16;
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  typedef enum logic [IDX_W-1:0] {
    CFG_CAM_INTRINSICS = 3'd0,
    CFG_REL_ROT_ROW0   = 3'd1,
    CFG_REL_ROT_ROW1   = 3'd2,
    CFG_REL_ROT_ROW2   = 3'd3,
    CFG_REL_TRANS      = 3'd4,
    CFG_REF_AXIS       = 3'd5,
    CFG_REF_ORIGIN     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [59:0] rot0;
    logic [59:0] rot1;
    logic [59:0] rot2;
    logic [62:0] trans;
    logic [59:0] axis;
    logic [62:0] origin;
  } geo_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > MAX32) return MAX32[31:0];
    if (v < MIN32) return MIN32[31:0];
    return v[31:0];
  endfunction
endpackage

FILE: rtl/mrt_isqrt.sv
// Pipelined integer square root of a 64-bit word, one result bit per stage.
// Carries a sideband word alongside; uses no package items.
`timescale 1ns / 1ps
module mrt_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_vld,
  input  logic [63:0]   in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);
  localparam int STEPS = 32;

  logic [63:0]   x    [STEPS+1];
  logic [63:0]   r    [STEPS+1];
  logic [SW-1:0] side [STEPS+1];
  logic          vld  [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_vld;
    end
    if (ce) begin
      x[0]    <= in_val;
      r[0]    <= '0;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = r[k] + BITV;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
      if (ce) begin
        side[k+1] <= side[k];
        if (x[k] >= trial) begin
          x[k+1] <= x[k] - trial;
          r[k+1] <= (r[k] >> 1) + BITV;
        end else begin
          x[k+1] <= x[k];
          r[k+1] <= r[k] >> 1;
        end
      end
    end
  end

  assign out_vld  = vld[STEPS];
  assign out_root = r[STEPS][31:0];
  assign out_side = side[STEPS];
endmodule

FILE: rtl/mrt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees that the numerator shifted down by QW is below the divisor.
`timescale 1ns / 1ps
module mrt_div #(
  parameter int NW = 49,
  parameter int DW = 31,
  parameter int QW = 19,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] out_side
);
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] acc  [QW+1];
  logic [DW-1:0] dv   [QW+1];
  logic [SW-1:0] side [QW+1];
  logic          vld  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_vld;
    end
    if (ce) begin
      rem[0]  <= DW'(num >> QW);
      acc[0]  <= num[QW-1:0];
      dv[0]   <= den;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] t;
    assign t = {rem[k], acc[k][QW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
      if (ce) begin
        side[k+1] <= side[k];
        dv[k+1]   <= dv[k];
        if (t >= {1'b0, dv[k]}) begin
          rem[k+1] <= DW'(t - {1'b0, dv[k]});
          acc[k+1] <= {acc[k][QW-2:0], 1'b1};
        end else begin
          rem[k+1] <= t[DW-1:0];
          acc[k+1] <= {acc[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld[QW];
  assign quot     = acc[QW];
  assign out_side = side[QW];
endmodule

FILE: rtl/mrt_ray.sv
// Back-projection of one pixel through the intrinsics and normalization to a unit ray.
// Depends on mrt_pkg, mrt_isqrt and mrt_div.
`timescale 1ns / 1ps
module mrt_ray (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ce,
  input  logic                               in_vld,
  input  logic [mrt_pkg::PX_W-1:0]           px,
  input  logic [mrt_pkg::PX_W-1:0]           py,
  input  logic [63:0]                        intr,
  output logic                               out_vld,
  output logic signed [mrt_pkg::RAY_W-1:0]   ray [3]
);
  logic [15:0] fx, fy, cx, cy;
  assign fx = intr[15:0];
  assign fy = intr[31:16];
  assign cx = intr[47:32];
  assign cy = intr[63:48];

  logic               v1, v2, v3, vo;
  logic signed [33:0] c [3];
  logic [33:0]        u [3];
  logic [33:0]        m;
  logic [29:0]        us [3];
  logic [29:0]        us2 [3];
  logic [2:0]         neg2;
  logic [29:0]        us3 [3];
  logic [2:0]         neg3;
  logic [59:0]        sq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = c[i][33] ? 34'(-c[i]) : 34'(c[i]);
    end
    m = u[0];
    if (u[1] > m) m = u[1];
    if (u[2] > m) m = u[2];
    for (int i = 0; i < 3; i++) begin
      if (m >= (34'd1 << 32)) us[i] = 30'(u[i] >> 3);
      else if (m >= (34'd1 << 31)) us[i] = 30'(u[i] >> 2);
      else if (m >= (34'd1 << 30)) us[i] = 30'(u[i] >> 1);
      else us[i] = 30'(u[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
    if (ce) begin
      c[0] <= ($signed({1'b0, px}) - $signed({1'b0, cx})) * $signed({1'b0, fy});
      c[1] <= ($signed({1'b0, py}) - $signed({1'b0, cy})) * $signed({1'b0, fx});
      c[2] <= $signed({18'b0, fx}) * $signed({18'b0, fy});
      for (int i = 0; i < 3; i++) begin
        us2[i]  <= us[i];
        neg2[i] <= c[i][33];
        us3[i]  <= us2[i];
        sq[i]   <= us2[i] * us2[i];
      end
      neg3 <= neg2;
    end
  end

  logic [63:0] n2;
  logic [92:0] sq_side, rt_side;
  logic        rt_vld;
  logic [31:0] nrm;
  assign n2 = {4'b0, sq[0]} + {4'b0, sq[1]} + {4'b0, sq[2]};
  assign sq_side = {neg3, us3[2], us3[1], us3[0]};

  mrt_isqrt #(.SW(93)) u_sqrt (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(v3), .in_val(n2), .in_side(sq_side),
    .out_vld(rt_vld), .out_root(nrm), .out_side(rt_side)
  );

  logic        nz;
  logic [2:0]  dvld;
  logic [18:0] q [3];
  logic [1:0]  dside [3];
  assign nz = (nrm == '0);

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [48:0] num;
    assign num = {1'b0, rt_side[30*i +: 30], 18'b0} + 49'(nrm[31:1]);
    mrt_div #(.NW(49), .DW(31), .QW(19), .SW(2)) u_div (
      .clk(clk), .rst(rst), .ce(ce), .in_vld(rt_vld), .num(num), .den(nrm[30:0]),
      .in_side({nz, rt_side[90+i]}), .out_vld(dvld[i]), .quot(q[i]), .out_side(dside[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (ce) begin
      vo <= &dvld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (dside[i][1]) ray[i] <= '0;
        else if (dside[i][0]) ray[i] <= -$signed({1'b0, q[i]});
        else ray[i] <= $signed({1'b0, q[i]});
      end
    end
  end

  assign out_vld = vo;
endmodule

FILE: rtl/mrt_solve.sv
// Rotation of the current ray, 2x2 solve for the ray scales, midpoint, norm and placement.
// Depends on mrt_pkg, mrt_div and mrt_isqrt.
`timescale 1ns / 1ps
module mrt_solve (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ce,
  input  logic                              in_vld,
  input  logic signed [mrt_pkg::RAY_W-1:0]  fr_in [3],
  input  logic signed [mrt_pkg::RAY_W-1:0]  fc_in [3],
  input  mrt_pkg::geo_cfg_t                 cfg,
  output logic                              out_vld,
  output logic signed [31:0]                point_x,
  output logic signed [31:0]                point_y,
  output logic signed [31:0]                point_z,
  output logic [30:0]                       depth_value,
  output logic                              rays_parallel
);
  localparam int RW = mrt_pkg::RAY_W;
  localparam int FW = mrt_pkg::F2_W;

  logic signed [19:0] rot [3][3];
  logic signed [20:0] t [3];
  logic signed [19:0] ax [3];
  logic signed [20:0] og [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rot[0][j] = $signed(cfg.rot0[20*j +: 20]);
      rot[1][j] = $signed(cfg.rot1[20*j +: 20]);
      rot[2][j] = $signed(cfg.rot2[20*j +: 20]);
      t[j]      = $signed(cfg.trans[21*j +: 21]);
      ax[j]     = $signed(cfg.axis[20*j +: 20]);
      og[j]     = $signed(cfg.origin[21*j +: 21]);
    end
  end

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v13, v14, vo;

  logic signed [39:0] p1 [3][3];
  logic signed [RW-1:0] fr1 [3], fr2 [3], fr3 [3], fr4 [3], fr5 [3], fr6 [3], fr7 [3];
  logic signed [41:0] f2s [3];
  logic signed [FW-1:0] f2_2 [3], f2_3 [3], f2_4 [3], f2_5 [3], f2_6 [3], f2_7 [3];
  logic signed [47:0] tfr [3], tf2 [3], frfr [3], frf2 [3], f2f2 [3];
  logic signed [47:0] sb0, sb1, sa0, sa2, sa3;
  logic signed [31:0] b0, b1, a0, a2, a3;
  logic signed [63:0] m_a0a3, m_a2a2, m_a3b0, m_a2b1, m_a2b0, m_a0b1;
  logic signed [47:0] det;
  logic signed [49:0] num0, num1;
  logic [49:0] un0, un1;
  logic [39:0] ud;
  logic        sg0, sg1, par7;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2s[i] = p1[i][0] + p1[i][1] + p1[i][2];
    end
    sb0 = tfr[0] + tfr[1] + tfr[2];
    sb1 = tf2[0] + tf2[1] + tf2[2];
    sa0 = frfr[0] + frfr[1] + frfr[2];
    sa2 = frf2[0] + frf2[1] + frf2[2];
    sa3 = f2f2[0] + f2f2[1] + f2f2[2];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1[i][j] <= rot[i][j] * fc_in[j];
        end
        fr1[i]  <= fr_in[i];
        fr2[i]  <= fr1[i];
        f2_2[i] <= FW'((f2s[i] + 42'sd131072) >>> 18);
        fr3[i]  <= fr2[i];
        f2_3[i] <= f2_2[i];
        tfr[i]  <= t[i] * fr2[i];
        tf2[i]  <= t[i] * f2_2[i];
        frfr[i] <= fr2[i] * fr2[i];
        frf2[i] <= fr2[i] * f2_2[i];
        f2f2[i] <= f2_2[i] * f2_2[i];
        fr4[i]  <= fr3[i];
        f2_4[i] <= f2_3[i];
        fr5[i]  <= fr4[i];
        f2_5[i] <= f2_4[i];
        fr6[i]  <= fr5[i];
        f2_6[i] <= f2_5[i];
        fr7[i]  <= fr6[i];
        f2_7[i] <= f2_6[i];
      end
      b0 <= 32'((sb0 + 48'sd131072) >>> 18);
      b1 <= 32'((sb1 + 48'sd131072) >>> 18);
      a0 <= 32'((sa0 + 48'sd131072) >>> 18);
      a2 <= 32'((sa2 + 48'sd131072) >>> 18);
      a3 <= -32'((sa3 + 48'sd131072) >>> 18);
      m_a0a3 <= a0 * a3;
      m_a2a2 <= a2 * a2;
      m_a3b0 <= a3 * b0;
      m_a2b1 <= a2 * b1;
      m_a2b0 <= a2 * b0;
      m_a0b1 <= a0 * b1;
      det  <= 48'((m_a0a3 + m_a2a2 + 64'sd128) >>> 8);
      num0 <= 50'(m_a3b0 + m_a2b1);
      num1 <= 50'(m_a0b1 - m_a2b0);
      un0  <= num0[49] ? 50'(-num0) : 50'(num0);
      un1  <= num1[49] ? 50'(-num1) : 50'(num1);
      ud   <= det[47] ? 40'(-det) : 40'(det);
      sg0  <= num0[49] ^ det[47];
      sg1  <= num1[49] ^ det[47];
      par7 <= (det == '0);
    end
  end

  logic [59:0]  n0, n1;
  logic         sat0, sat1;
  logic [128:0] side0, oside0;
  logic [1:0]   oside1;
  logic         d0_vld, d1_vld;
  logic [30:0]  q0, q1;

  always_comb begin
    n0 = {un0, 10'b0} + {21'b0, ud[39:1]};
    n1 = {un1, 10'b0} + {21'b0, ud[39:1]};
    sat0 = ({11'b0, n0[59:31]} >= ud);
    sat1 = ({11'b0, n1[59:31]} >= ud);
    side0 = '0;
    side0[0] = sat0;
    side0[1] = sg0;
    side0[2] = par7;
    for (int i = 0; i < 3; i++) begin
      side0[3+FW*i +: FW]  = f2_7[i];
      side0[69+RW*i +: RW] = fr7[i];
    end
  end

  mrt_div #(.NW(60), .DW(40), .QW(31), .SW(129)) u_div0 (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(v7), .num(n0), .den(ud), .in_side(side0),
    .out_vld(d0_vld), .quot(q0), .out_side(oside0)
  );
  mrt_div #(.NW(60), .DW(40), .QW(31), .SW(2)) u_div1 (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(v7), .num(n1), .den(ud), .in_side({sg1, sat1}),
    .out_vld(d1_vld), .quot(q1), .out_side(oside1)
  );

  logic [30:0] qs0, qs1;
  logic signed [31:0] l0, l1;
  logic signed [RW-1:0] fr8 [3];
  logic signed [FW-1:0] f2_8 [3];
  logic par8, par9, par10, par11;
  logic signed [55:0] pl0 [3], pl1 [3], ms [3];
  logic signed [31:0] mid [3];
  logic [31:0] mg [3];
  logic [63:0] sq [3];

  always_comb begin
    qs0 = oside0[0] ? 31'h7FFFFFFF : q0;
    qs1 = oside1[0] ? 31'h7FFFFFFF : q1;
    for (int i = 0; i < 3; i++) begin
      ms[i] = pl0[i] + (56'(t[i]) <<< 18) + pl1[i];
      mg[i] = mid[i][31] ? 32'(-mid[i]) : 32'(mid[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      l0 <= oside0[1] ? -$signed({1'b0, qs0}) : $signed({1'b0, qs0});
      l1 <= oside1[1] ? -$signed({1'b0, qs1}) : $signed({1'b0, qs1});
      par8 <= oside0[2];
      for (int i = 0; i < 3; i++) begin
        f2_8[i] <= $signed(oside0[3+FW*i +: FW]);
        fr8[i]  <= $signed(oside0[69+RW*i +: RW]);
        pl0[i]  <= l0 * fr8[i];
        pl1[i]  <= l1 * f2_8[i];
        mid[i]  <= mrt_pkg::sat32(64'((ms[i] + 56'sd262144) >>> 19));
        sq[i]   <= mg[i] * mg[i];
      end
      par9  <= par8;
      par10 <= par9;
      par11 <= par10;
    end
  end

  logic [63:0] n2;
  logic        rt_vld, rt_par;
  logic [31:0] root;
  assign n2 = sq[0] + sq[1] + sq[2];

  mrt_isqrt #(.SW(1)) u_sqrt (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(v11), .in_val(n2), .in_side(par11),
    .out_vld(rt_vld), .out_root(root), .out_side(rt_par)
  );

  logic [30:0] dep13, dep14;
  logic        par13, par14;
  logic signed [55:0] pa [3], ps [3];
  logic signed [31:0] pnt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps[i] = pa[i] + (56'(og[i]) <<< 18) + 56'sd131072;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dep13 <= root[31] ? 31'h7FFFFFFF : root[30:0];
      par13 <= rt_par;
      dep14 <= dep13;
      par14 <= par13;
      for (int i = 0; i < 3; i++) begin
        pa[i]  <= ax[i] * $signed({1'b0, dep13});
        pnt[i] <= par14 ? '0 : mrt_pkg::sat32(64'(ps[i] >>> 18));
      end
      depth_value   <= par14 ? '0 : dep14;
      rays_parallel <= par14;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v13, v14, vo} <= '0;
    end else if (ce) begin
      v1  <= in_vld;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= d0_vld & d1_vld;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      v13 <= rt_vld;
      v14 <= v13;
      vo  <= v14;
    end
  end

  assign out_vld = vo;
  assign point_x = pnt[0];
  assign point_y = pnt[1];
  assign point_z = pnt[2];
endmodule

FILE: rtl/midpoint_ray_triangulation.sv
// Top level of the two-view midpoint triangulation block: configuration registers,
// flow control and word packing. Depends on mrt_pkg, mrt_ray and mrt_solve.
//
// Usage: each input word on s_* carries one matched keypoint pair; each output word
// on m_* carries the placed world point, its depth and the parallel-ray flag.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data while the block
// is idle; writes to an unused index are ignored.
// The path from s_* to m_* runs through 136 register stages: 57 stages in the ray
// part (its square root and dividers dominate) and 79 in the solve part (the 31-bit
// scale dividers and the 32-step norm square root dominate).
// Throughput is one word per cycle when not stalled; every stage is a pipeline register.
// Reset clears all configuration registers and all pipeline valid bits.
// When the receiver stalls, the whole pipeline holds in place and s_tready drops;
// nothing is lost or repeated.
`timescale 1ns / 1ps
module midpoint_ray_triangulation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // ref_px_x, ref_px_y, cur_px_x, cur_px_y
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [127:0]                  m_tdata,   // point_x, point_y, point_z, depth_value
  output logic [0:0]                    m_tuser,   // rays_parallel
  input  logic                          cfg_wr_en,
  input  logic [mrt_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mrt_pkg::CFG_W-1:0]     cfg_data
);
  logic [63:0]       cam_intrinsics;
  mrt_pkg::geo_cfg_t geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_intrinsics <= '0;
      geo            <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mrt_pkg::CFG_CAM_INTRINSICS: cam_intrinsics <= cfg_data;
        mrt_pkg::CFG_REL_ROT_ROW0:   geo.rot0   <= cfg_data[59:0];
        mrt_pkg::CFG_REL_ROT_ROW1:   geo.rot1   <= cfg_data[59:0];
        mrt_pkg::CFG_REL_ROT_ROW2:   geo.rot2   <= cfg_data[59:0];
        mrt_pkg::CFG_REL_TRANS:      geo.trans  <= cfg_data[62:0];
        mrt_pkg::CFG_REF_AXIS:       geo.axis   <= cfg_data[59:0];
        mrt_pkg::CFG_REF_ORIGIN:     geo.origin <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  logic ce;
  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic ref_vld, cur_vld;
  logic signed [mrt_pkg::RAY_W-1:0] fr [3];
  logic signed [mrt_pkg::RAY_W-1:0] fc [3];

  mrt_ray u_ref_ray (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(s_tvalid),
    .px(s_tdata[15:0]), .py(s_tdata[31:16]), .intr(cam_intrinsics),
    .out_vld(ref_vld), .ray(fr)
  );
  mrt_ray u_cur_ray (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(s_tvalid),
    .px(s_tdata[47:32]), .py(s_tdata[63:48]), .intr(cam_intrinsics),
    .out_vld(cur_vld), .ray(fc)
  );

  logic signed [31:0] px, py, pz;
  logic [30:0]        depth;
  logic               par;

  mrt_solve u_solve (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(ref_vld & cur_vld),
    .fr_in(fr), .fc_in(fc), .cfg(geo), .out_vld(m_tvalid),
    .point_x(px), .point_y(py), .point_z(pz), .depth_value(depth), .rays_parallel(par)
  );

  assign m_tdata = {1'b0, depth, pz, py, px};
  assign m_tuser = par;
endmodule
